/* design/swhv_pkg.sv */
// Shared types and constants for the sliding-window historical VaR unit.
package swhv_pkg;

    localparam int SAMPLE_W = 32;
    localparam int PROB_W   = 17;
    localparam int COUNT_W  = 9;
    localparam int FRAC_W   = 16;

    localparam logic [PROB_W-1:0]   TAIL_PROB_RESET = 17'd3277;
    localparam logic [PROB_W-1:0]   PROB_ONE        = 17'h10000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN      = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OLD,
        ST_FIND,
        ST_SHL,
        ST_PREP,
        ST_INS,
        ST_INS0,
        ST_CALC,
        ST_QA,
        ST_QB,
        ST_QC,
        ST_SUM,
        ST_MUL,
        ST_MUL2,
        ST_DIV,
        ST_OUT
    } swhv_state_t;

endpackage

/* design/swhv_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port (read-first).
module swhv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/swhv_div.sv */
// Iterative restoring divider for unsigned magnitudes, one quotient bit per cycle.
module swhv_div #(
    parameter int NW = 40,
    parameter int DW = 9
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [DW:0]      rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;

    always_comb begin
        trial     = {rem_reg[DW-1:0], quo_reg[NW-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = CNT_W'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/sliding_window_historical_var_unit.sv */
// Sliding-window historical VaR / CVaR unit: top level with sort sequencer and datapath.
//
// Each return sample (Q8.24) enters a window of the newest WINDOW_DEPTH samples, held in an
// arrival-order RAM and a sorted RAM. One result (VaR, CVaR, sample count) follows each sample.
// For each sample, a full window first has the evicted value searched and the tail closed up
// (one sorted-RAM entry per cycle), then the new value is inserted by a downward scan, the
// tail of k entries (k being the tail count) is summed one entry per cycle, and the mean comes
// from a bit-serial divider. A new sample is taken as soon as the previous result sits in the
// output register.
// Configuration writes are taken whenever the block is out of reset.
module sliding_window_historical_var_unit
    import swhv_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] return_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [31:0] var_value, [63:32] cvar_value,
                                    // [72:64] sample_count, [79:73] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data    // tail_prob
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int PW    = PROB_W + CW;
    localparam int SUM_W = SAMPLE_W + AW;

    swhv_state_t state_reg, state_next;

    logic [PROB_W-1:0]   tail_reg;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [SAMPLE_W-1:0] x_reg, x_next;
    logic [SAMPLE_W-1:0] old_reg, old_next;
    logic [PROB_W-1:0]   p_reg, p_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [SAMPLE_W-1:0] a_reg, a_next;
    logic [SAMPLE_W-1:0] b_reg, b_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [49:0]  pa_reg, pb_reg;
    logic [SAMPLE_W-1:0] q_reg;
    logic                m_tvalid_reg;
    logic [79:0]         m_tdata_reg;

    logic [SAMPLE_W-1:0] ring_rdata;
    logic [SAMPLE_W-1:0] srt_rdata;
    logic                srt_we;
    logic [AW-1:0]       srt_waddr;
    logic [SAMPLE_W-1:0] srt_wdata;

    logic                s_accept, full, ptr_last, ins_gt, out_free, sum_last;
    logic [PW-1:0]       kp;
    logic [CW:0]         k_raw;
    logic [CW-1:0]       lo;
    logic                use_a;
    logic signed [50:0]  q_sum;
    logic                div_start, div_done;
    logic [SUM_W-1:0]    div_quo, sum_mag;
    logic                sum_neg, quo_big;
    logic [SAMPLE_W-1:0] var_out, cvar_out;

    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign cfg_ready = aresetn;
    assign s_accept  = s_tvalid && s_tready;
    assign full      = (fill_reg == CW'(WINDOW_DEPTH));
    assign ptr_last  = (ptr_reg == fill_reg - 1'b1);
    assign ins_gt    = $signed(srt_rdata) > $signed(x_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign sum_last  = (ptr_reg == k_reg - 1'b1);

    assign kp    = PW'(p_reg) * PW'(fill_reg);
    assign k_raw = kp[PW-1:16];
    assign lo    = CW'(pos_reg[PW-1:16]);
    assign use_a = (pos_reg[15:0] == '0) || (lo == fill_reg - 1'b1);
    assign q_sum = 51'(pa_reg) + 51'(pb_reg);

    assign sum_neg = sum_reg[SUM_W-1];
    assign sum_mag = sum_neg ? (~sum_reg + 1'b1) : sum_reg;
    assign quo_big = |div_quo[SUM_W-1:31];
    assign var_out = (q_reg == SAMPLE_MIN) ? SAMPLE_MAX : (~q_reg + 1'b1);
    assign cvar_out = sum_neg ? (quo_big ? SAMPLE_MAX : div_quo[31:0])
                              : (~div_quo[31:0] + 1'b1);

    swhv_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (head_reg),
        .wdata (s_tdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    swhv_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_sorted (
        .aclk  (aclk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (srt_wdata),
        .raddr (ptr_next[AW-1:0]),
        .rdata (srt_rdata)
    );

    swhv_div #(.NW(SUM_W), .DW(CW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (k_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = full ? ST_OLD : ST_PREP;
            ST_OLD:  state_next = ST_FIND;
            ST_FIND: if (srt_rdata == old_reg) state_next = ptr_last ? ST_PREP : ST_SHL;
            ST_SHL:  if (ptr_last) state_next = ST_PREP;
            ST_PREP: state_next = (fill_reg == '0) ? ST_CALC : ST_INS;
            ST_INS: begin
                if (!ins_gt) state_next = ST_CALC;
                else if (ptr_reg == '0) state_next = ST_INS0;
            end
            ST_INS0: state_next = ST_CALC;
            ST_CALC: state_next = ST_QA;
            ST_QA:   state_next = ST_QB;
            ST_QB:   state_next = ST_QC;
            ST_QC:   state_next = ST_SUM;
            ST_SUM:  if (sum_last) state_next = ST_MUL;
            ST_MUL:  state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        x_next    = x_reg;
        old_next  = old_reg;
        p_next    = p_reg;
        pos_next  = pos_reg;
        k_next    = k_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        sum_next  = sum_reg;
        srt_we    = 1'b0;
        srt_waddr = '0;
        srt_wdata = x_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    x_next    = s_tdata;
                    p_next    = tail_reg[16] ? PROB_ONE : tail_reg;
                    head_next = (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                end
            end
            ST_OLD: begin
                old_next = ring_rdata;
                ptr_next = '0;
            end
            ST_FIND: begin
                ptr_next = ptr_reg + 1'b1;
                if (srt_rdata == old_reg && ptr_last) begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            ST_SHL: begin
                srt_we    = 1'b1;
                srt_waddr = AW'(ptr_reg - 1'b1);
                srt_wdata = srt_rdata;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_last) begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            ST_PREP: begin
                if (fill_reg == '0) begin
                    srt_we    = 1'b1;
                    srt_waddr = '0;
                    fill_next = fill_reg + 1'b1;
                end else begin
                    ptr_next = fill_reg - 1'b1;
                end
            end
            ST_INS: begin
                srt_we    = 1'b1;
                srt_waddr = AW'(ptr_reg + 1'b1);
                if (ins_gt) begin
                    srt_wdata = srt_rdata;
                    ptr_next  = ptr_reg - 1'b1;
                end else begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            ST_INS0: begin
                srt_we    = 1'b1;
                srt_waddr = '0;
                fill_next = fill_reg + 1'b1;
            end
            ST_CALC: begin
                pos_next = PW'(p_reg) * PW'(fill_reg - 1'b1);
                k_next   = (k_raw == '0) ? CW'(1) : CW'(k_raw);
            end
            ST_QA: ptr_next = lo;
            ST_QB: begin
                a_next   = srt_rdata;
                ptr_next = lo + 1'b1;
            end
            ST_QC: begin
                b_next   = srt_rdata;
                ptr_next = '0;
                sum_next = '0;
            end
            ST_SUM: begin
                sum_next = sum_reg + SUM_W'($signed(srt_rdata));
                ptr_next = ptr_reg + 1'b1;
            end
            ST_MUL:  div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tail_reg     <= TAIL_PROB_RESET;
            head_reg     <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            if (cfg_valid) begin
                tail_reg <= cfg_data;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        ptr_reg <= ptr_next;
        x_reg   <= x_next;
        old_reg <= old_next;
        p_reg   <= p_next;
        pos_reg <= pos_next;
        k_reg   <= k_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        sum_reg <= sum_next;
        if (state_reg == ST_MUL) begin
            pa_reg <= $signed(a_reg) * $signed({2'b00, 16'(17'h10000 - 17'(pos_reg[15:0]))});
            pb_reg <= $signed(b_reg) * $signed({2'b00, pos_reg[15:0]});
        end
        if (state_reg == ST_MUL2) begin
            q_reg <= use_a ? a_reg : q_sum[47:16];
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {7'd0, COUNT_W'(fill_reg), cvar_out, var_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
